>>> rtl/mfw_pkg.sv
// ----------------------------------------------------------------------------
// mfw_pkg
// Shared types and constants for the mecanum four-wheel speed controller.
// ----------------------------------------------------------------------------
package mfw_pkg;

  localparam int NUM_WHEELS = 4;
  localparam int N_STG      = 5;   // lane pipeline stages

  // Field widths
  localparam int TGT_W   = 16;  // input target / measurement fields
  localparam int DUTY_W  = 16;
  localparam int GAIN_W  = 32;
  localparam int ILIM_W  = 15;
  localparam int MIX_W   = 18;  // mixed wheel target
  localparam int MEAS_W  = 17;  // measurement after optional negation
  localparam int ERR_W   = 19;
  localparam int FILT_W  = 18;
  localparam int INTEG_W = 16;
  localparam int DIFF_W  = 20;
  localparam int SUM_W   = 37;  // full width PID sum

  // Q15.16 products
  localparam int FRAC_BITS = 16;
  localparam logic [FRAC_BITS-1:0] Q_ROUND = '1;

  // Divide by five as multiply by reciprocal, exact for magnitudes below 2^22
  localparam int DIV5_IN_W  = 20;
  localparam int DIV5_SHIFT = 22;
  localparam logic [DIV5_IN_W-1:0] DIV5_MULT = 20'd838861;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIM  = 3'd4;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST = -32'sd41287680;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST = -32'sd8520;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 32'sd0;
  localparam logic [ILIM_W-1:0]        ILIM_RST   = 15'd10000;
  localparam logic [DUTY_W-1:0]        DLIM_RST   = 16'd8000;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [ILIM_W-1:0]        integral_limit;
    logic [DUTY_W-1:0]        duty_limit;
  } mfw_cfg_t;

  // Per-stage load strobes, shared by all lanes
  typedef struct packed {
    logic [N_STG-1:0] ld;
  } mfw_ld_t;

endpackage

>>> rtl/mfw_in_if.sv
// ----------------------------------------------------------------------------
// mfw_in_if
// Input channel: motion targets and measured wheel speeds for one tick.
// ----------------------------------------------------------------------------
interface mfw_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [15:0]       vel_x;
  logic signed [15:0]       vel_y;
  logic signed [15:0]       target_turn;
  logic signed [15:0]       meas_wheel1;
  logic signed [15:0]       meas_wheel2;
  logic signed [15:0]       meas_wheel3;
  logic signed [15:0]       meas_wheel4;

  modport source (
    output valid, vel_x, vel_y, target_turn,
           meas_wheel1, meas_wheel2, meas_wheel3, meas_wheel4,
    input  ready
  );

  modport sink (
    input  valid, vel_x, vel_y, target_turn,
           meas_wheel1, meas_wheel2, meas_wheel3, meas_wheel4,
    output ready
  );
endinterface

>>> rtl/mfw_out_if.sv
// ----------------------------------------------------------------------------
// mfw_out_if
// Result channel: drive duty and direction for each wheel.
// ----------------------------------------------------------------------------
interface mfw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty_wheel1;
  logic [15:0] duty_wheel2;
  logic [15:0] duty_wheel3;
  logic [15:0] duty_wheel4;
  logic        dir_wheel1;
  logic        dir_wheel2;
  logic        dir_wheel3;
  logic        dir_wheel4;

  modport source (
    output valid, duty_wheel1, duty_wheel2, duty_wheel3, duty_wheel4,
           dir_wheel1, dir_wheel2, dir_wheel3, dir_wheel4,
    input  ready
  );

  modport sink (
    input  valid, duty_wheel1, duty_wheel2, duty_wheel3, duty_wheel4,
           dir_wheel1, dir_wheel2, dir_wheel3, dir_wheel4,
    output ready
  );
endinterface

>>> rtl/mfw_cfg.sv
// ----------------------------------------------------------------------------
// mfw_cfg
// APB-style register file holding PID gains and limits.
// ----------------------------------------------------------------------------
module mfw_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mfw_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [mfw_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [mfw_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output mfw_pkg::mfw_cfg_t                 cfg
);

  mfw_pkg::mfw_cfg_t              cfg_r;
  mfw_pkg::mfw_cfg_t              cfg_nxt;
  logic [mfw_pkg::CFG_IDX_W-1:0]  idx;
  logic                           wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[mfw_pkg::CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        mfw_pkg::REG_GAIN_P:    cfg_nxt.gain_p = pwdata;
        mfw_pkg::REG_GAIN_I:    cfg_nxt.gain_i = pwdata;
        mfw_pkg::REG_GAIN_D:    cfg_nxt.gain_d = pwdata;
        mfw_pkg::REG_INT_LIMIT: cfg_nxt.integral_limit = pwdata[mfw_pkg::ILIM_W-1:0];
        mfw_pkg::REG_DUTY_LIM:  cfg_nxt.duty_limit = pwdata[mfw_pkg::DUTY_W-1:0];
        default:                ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= mfw_pkg::GAIN_P_RST;
      cfg_r.gain_i         <= mfw_pkg::GAIN_I_RST;
      cfg_r.gain_d         <= mfw_pkg::GAIN_D_RST;
      cfg_r.integral_limit <= mfw_pkg::ILIM_RST;
      cfg_r.duty_limit     <= mfw_pkg::DLIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      mfw_pkg::REG_GAIN_P:    prdata = cfg_r.gain_p;
      mfw_pkg::REG_GAIN_I:    prdata = cfg_r.gain_i;
      mfw_pkg::REG_GAIN_D:    prdata = cfg_r.gain_d;
      mfw_pkg::REG_INT_LIMIT: prdata = {{(mfw_pkg::CFG_DATA_W-mfw_pkg::ILIM_W){1'b0}},
                                        cfg_r.integral_limit};
      mfw_pkg::REG_DUTY_LIM:  prdata = {{(mfw_pkg::CFG_DATA_W-mfw_pkg::DUTY_W){1'b0}},
                                        cfg_r.duty_limit};
      default:                prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/mfw_lane.sv
// ----------------------------------------------------------------------------
// mfw_lane
// One wheel's PID pipeline: error, low-pass, integral and derivative, products, sum.
// ----------------------------------------------------------------------------
module mfw_lane (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mfw_pkg::mfw_ld_t                      ld,
  input  mfw_pkg::mfw_cfg_t                     cfg,
  input  logic signed [mfw_pkg::MIX_W-1:0]      target,
  input  logic signed [mfw_pkg::MEAS_W-1:0]     meas,
  output logic signed [mfw_pkg::SUM_W-1:0]      pid_sum,
  output logic                                  dir
);

  // Stage 0: error and direction
  logic signed [mfw_pkg::ERR_W-1:0]   err0_r;
  logic                               dir0_r;
  logic                               dir0_nxt;

  // Stage 1: low-pass filter (filt_r is also the filter state)
  logic signed [mfw_pkg::FILT_W-1:0]  filt_r;
  logic signed [mfw_pkg::FILT_W-1:0]  filt_nxt;
  logic signed [mfw_pkg::ERR_W-1:0]   err1_r;
  logic                               dir1_r;
  logic signed [mfw_pkg::FILT_W+2:0]  filt_x4;
  logic signed [mfw_pkg::FILT_W+2:0]  acc;
  logic        [mfw_pkg::FILT_W+2:0]  acc_neg;
  logic        [mfw_pkg::DIV5_IN_W-1:0] acc_mag;
  logic        [2*mfw_pkg::DIV5_IN_W-1:0] div_prod;
  logic        [mfw_pkg::FILT_W-2:0]  quot;

  // Stage 2: integral and derivative (integ_r, perr_r are state)
  logic signed [mfw_pkg::INTEG_W-1:0] integ_r;
  logic signed [mfw_pkg::ERR_W-1:0]   perr_r;
  logic signed [mfw_pkg::DIFF_W-1:0]  diff_r;
  logic signed [mfw_pkg::ERR_W-1:0]   err2_r;
  logic                               dir2_r;
  logic signed [mfw_pkg::ERR_W-1:0]   isum;
  logic signed [mfw_pkg::ERR_W-1:0]   ilim;
  logic signed [mfw_pkg::ERR_W-1:0]   iclamp;

  // Stage 3: raw Q15.16 products
  localparam int PP_W = mfw_pkg::GAIN_W + mfw_pkg::ERR_W;
  localparam int PI_W = mfw_pkg::GAIN_W + mfw_pkg::INTEG_W;
  localparam int PD_W = mfw_pkg::GAIN_W + mfw_pkg::DIFF_W;
  logic signed [PP_W-1:0] pp_r;
  logic signed [PI_W-1:0] pi_r;
  logic signed [PD_W-1:0] pd_r;
  logic signed [PP_W-1:0] pp_nxt;
  logic signed [PI_W-1:0] pi_nxt;
  logic signed [PD_W-1:0] pd_nxt;
  logic                   dir3_r;

  // Stage 4: truncate toward zero and add
  logic signed [PP_W-1:0] pp_adj;
  logic signed [PI_W-1:0] pi_adj;
  logic signed [PD_W-1:0] pd_adj;
  logic signed [mfw_pkg::SUM_W-1:0] sum_r;
  logic signed [mfw_pkg::SUM_W-1:0] sum_nxt;
  logic                             dir4_r;

  // ---- stage 0 ----
  always_comb begin
    dir0_nxt = dir0_r;
    if (target > 0)      dir0_nxt = 1'b1;
    else if (target < 0) dir0_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir0_r <= 1'b0;
    end else if (ld.ld[0]) begin
      dir0_r <= dir0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld[0]) begin
      err0_r <= mfw_pkg::ERR_W'(meas) - mfw_pkg::ERR_W'(target);
    end
  end

  // ---- stage 1: f = (e + 4*f_prev) / 5, truncated toward zero ----
  assign filt_x4  = {filt_r[mfw_pkg::FILT_W-1], filt_r, 2'b00};
  assign acc      = (mfw_pkg::FILT_W+3)'(err0_r) + filt_x4;
  assign acc_neg  = -acc;
  assign acc_mag  = acc[mfw_pkg::FILT_W+2] ? acc_neg[mfw_pkg::DIV5_IN_W-1:0]
                                           : acc[mfw_pkg::DIV5_IN_W-1:0];
  assign div_prod = {{mfw_pkg::DIV5_IN_W{1'b0}}, acc_mag} *
                    {{mfw_pkg::DIV5_IN_W{1'b0}}, mfw_pkg::DIV5_MULT};
  assign quot     = div_prod[mfw_pkg::DIV5_SHIFT +: (mfw_pkg::FILT_W-1)];
  assign filt_nxt = acc[mfw_pkg::FILT_W+2] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else if (ld.ld[1]) begin
      filt_r <= filt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld[1]) begin
      err1_r <= err0_r;
      dir1_r <= dir0_r;
    end
  end

  // ---- stage 2: clamp integral, take derivative against previous error ----
  assign isum = mfw_pkg::ERR_W'(integ_r) + mfw_pkg::ERR_W'(filt_r);
  assign ilim = $signed({{(mfw_pkg::ERR_W-mfw_pkg::ILIM_W){1'b0}}, cfg.integral_limit});

  always_comb begin
    iclamp = isum;
    if (isum > ilim)       iclamp = ilim;
    else if (isum < -ilim) iclamp = -ilim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      perr_r  <= '0;
    end else if (ld.ld[2]) begin
      integ_r <= iclamp[mfw_pkg::INTEG_W-1:0];
      perr_r  <= err1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld[2]) begin
      diff_r <= mfw_pkg::DIFF_W'(err1_r) - mfw_pkg::DIFF_W'(perr_r);
      err2_r <= err1_r;
      dir2_r <= dir1_r;
    end
  end

  // ---- stage 3: one multiplier per gain ----
  assign pp_nxt = PP_W'(cfg.gain_p) * PP_W'(err2_r);
  assign pi_nxt = PI_W'(cfg.gain_i) * PI_W'(integ_r);
  assign pd_nxt = PD_W'(cfg.gain_d) * PD_W'(diff_r);

  always_ff @(posedge clk) begin
    if (ld.ld[3]) begin
      pp_r   <= pp_nxt;
      pi_r   <= pi_nxt;
      pd_r   <= pd_nxt;
      dir3_r <= dir2_r;
    end
  end

  // ---- stage 4: bias negatives before the shift to truncate toward zero ----
  assign pp_adj = pp_r + (pp_r[PP_W-1] ? $signed({{(PP_W-mfw_pkg::FRAC_BITS){1'b0}},
                                                   mfw_pkg::Q_ROUND}) : '0);
  assign pi_adj = pi_r + (pi_r[PI_W-1] ? $signed({{(PI_W-mfw_pkg::FRAC_BITS){1'b0}},
                                                   mfw_pkg::Q_ROUND}) : '0);
  assign pd_adj = pd_r + (pd_r[PD_W-1] ? $signed({{(PD_W-mfw_pkg::FRAC_BITS){1'b0}},
                                                   mfw_pkg::Q_ROUND}) : '0);

  assign sum_nxt = mfw_pkg::SUM_W'($signed(pp_adj[PP_W-1:mfw_pkg::FRAC_BITS]))
                 + mfw_pkg::SUM_W'($signed(pi_adj[PI_W-1:mfw_pkg::FRAC_BITS]))
                 + mfw_pkg::SUM_W'($signed(pd_adj[PD_W-1:mfw_pkg::FRAC_BITS]));

  always_ff @(posedge clk) begin
    if (ld.ld[4]) begin
      sum_r  <= sum_nxt;
      dir4_r <= dir3_r;
    end
  end

  assign pid_sum = sum_r;
  assign dir     = dir4_r;

endmodule

>>> rtl/mecanum_four_wheel_speed_pid.sv
// ----------------------------------------------------------------------------
// mecanum_four_wheel_speed_pid
// Four-lane mecanum wheel speed controller with per-wheel PI(D) loops.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one control tick: X, Y and rotation targets plus the four
//   measured wheel speeds (wheel two's reading is negated internally).
//   out_ch returns one result per tick: four saturated duties and four
//   direction bits. Both channels transfer on valid && ready.
//   The cfg_ port is APB-style, always ready, one 32-bit register per word:
//   gain_p, gain_i, gain_d, integral_limit, duty_limit. Write it only while
//   no tick is in flight.
//   Path: each tick passes through the five lane stages, then the merged
//   output register.
//   Throughput: one tick per cycle while out_ch is ready. Each stage is one
//   register per lane; the filter and integral feedback loops each close inside a single stage.
//   Stall: when out_ch.ready is low the output register holds, and the lane
//   stages keep advancing until they fill; in_ch.ready drops only once the
//   whole pipe is full.
//   Reset: filter, integral, previous-error and direction state per wheel go
//   to zero (direction reverse); gains and limits return to their defaults.
// ----------------------------------------------------------------------------
module mecanum_four_wheel_speed_pid (
  input  logic                               clk,
  input  logic                               rst_n,
  mfw_in_if.sink                             in_ch,
  mfw_out_if.source                          out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [mfw_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [mfw_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [mfw_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  mfw_pkg::mfw_cfg_t                      cfg;
  mfw_pkg::mfw_ld_t                       ld;

  // Pipeline control
  logic [mfw_pkg::N_STG-1:0]              v_r;
  logic [mfw_pkg::N_STG-1:0]              v_nxt;
  logic [mfw_pkg::N_STG-1:0]              move;
  logic                                   out_v_r;
  logic                                   out_v_nxt;
  logic                                   in_xfer;

  // Lane inputs and outputs
  logic signed [mfw_pkg::MIX_W-1:0]       tgt  [mfw_pkg::NUM_WHEELS];
  logic signed [mfw_pkg::MEAS_W-1:0]      meas [mfw_pkg::NUM_WHEELS];
  logic signed [mfw_pkg::SUM_W-1:0]       lane_sum [mfw_pkg::NUM_WHEELS];
  logic                                   lane_dir [mfw_pkg::NUM_WHEELS];
  logic signed [mfw_pkg::MIX_W-1:0]       tx;
  logic signed [mfw_pkg::MIX_W-1:0]       ty;
  logic signed [mfw_pkg::MIX_W-1:0]       tt;

  // Merged output register
  logic [mfw_pkg::DUTY_W-1:0]             duty_r   [mfw_pkg::NUM_WHEELS];
  logic [mfw_pkg::DUTY_W-1:0]             duty_nxt [mfw_pkg::NUM_WHEELS];
  logic                                   dir_r    [mfw_pkg::NUM_WHEELS];

  mfw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // A stage advances when its item can move into an empty or moving successor;
  // the last lane stage feeds the output register.
  always_comb begin
    move[mfw_pkg::N_STG-1] = v_r[mfw_pkg::N_STG-1] && (!out_v_r || out_ch.ready);
    for (int i = mfw_pkg::N_STG-2; i >= 0; i--) begin
      move[i] = v_r[i] && (!v_r[i+1] || move[i+1]);
    end
  end

  assign in_ch.ready = !v_r[0] || move[0];
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    ld.ld[0] = in_xfer;
    for (int i = 1; i < mfw_pkg::N_STG; i++) begin
      ld.ld[i] = move[i-1];
    end
    v_nxt     = ld.ld | (v_r & ~move);
    out_v_nxt = move[mfw_pkg::N_STG-1] || (out_v_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else begin
      v_r     <= v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Mecanum mixing: w1 = x+y-t, w2 = -x+y+t, w3 = -x+y-t, w4 = x+y+t
  assign tx = mfw_pkg::MIX_W'(in_ch.vel_x);
  assign ty = mfw_pkg::MIX_W'(in_ch.vel_y);
  assign tt = mfw_pkg::MIX_W'(in_ch.target_turn);

  assign tgt[0] =  tx + ty - tt;
  assign tgt[1] = -tx + ty + tt;
  assign tgt[2] = -tx + ty - tt;
  assign tgt[3] =  tx + ty + tt;

  // Wheel two's encoder counts the other way; widen first so -32768 survives
  assign meas[0] =  mfw_pkg::MEAS_W'(in_ch.meas_wheel1);
  assign meas[1] = -mfw_pkg::MEAS_W'(in_ch.meas_wheel2);
  assign meas[2] =  mfw_pkg::MEAS_W'(in_ch.meas_wheel3);
  assign meas[3] =  mfw_pkg::MEAS_W'(in_ch.meas_wheel4);

  for (genvar k = 0; k < mfw_pkg::NUM_WHEELS; k++) begin : g_lane
    mfw_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ld      (ld),
      .cfg     (cfg),
      .target  (tgt[k]),
      .meas    (meas[k]),
      .pid_sum (lane_sum[k]),
      .dir     (lane_dir[k])
    );
  end

  // Merge: absolute value of each lane's PID sum, saturated at duty_limit
  always_comb begin
    logic [mfw_pkg::SUM_W-1:0] mag;
    for (int k = 0; k < mfw_pkg::NUM_WHEELS; k++) begin
      mag = lane_sum[k][mfw_pkg::SUM_W-1] ? mfw_pkg::SUM_W'(-lane_sum[k])
                                          : mfw_pkg::SUM_W'(lane_sum[k]);
      if (mag > {{(mfw_pkg::SUM_W-mfw_pkg::DUTY_W){1'b0}}, cfg.duty_limit}) begin
        duty_nxt[k] = cfg.duty_limit;
      end else begin
        duty_nxt[k] = mag[mfw_pkg::DUTY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move[mfw_pkg::N_STG-1]) begin
      for (int k = 0; k < mfw_pkg::NUM_WHEELS; k++) begin
        duty_r[k] <= duty_nxt[k];
        dir_r[k]  <= lane_dir[k];
      end
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.duty_wheel1 = duty_r[0];
  assign out_ch.duty_wheel2 = duty_r[1];
  assign out_ch.duty_wheel3 = duty_r[2];
  assign out_ch.duty_wheel4 = duty_r[3];
  assign out_ch.dir_wheel1  = dir_r[0];
  assign out_ch.dir_wheel2  = dir_r[1];
  assign out_ch.dir_wheel3  = dir_r[2];
  assign out_ch.dir_wheel4  = dir_r[3];

endmodule
